### rtl/core/mzrt_pkg.sv
// Shared types and codes for the multi-zone relay timer.
// Depends on nothing; every other file of the block imports it.
package mzrt_pkg;

  // One input word: operation, zone and requested run length.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  zone;
    logic [15:0] duration_s;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [2:0]  event_res;
    logic [2:0]  zone_out;
    logic        zone_active;
    logic [15:0] granted_s;
    logic [15:0] ran_for_s;
    logic [15:0] remaining_s;
    logic [31:0] last_end_time;
    logic [15:0] last_run_s;
    logic [7:0]  relay_mask;
    logic        last;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take the input word, advance the clock on a tick
    logic scan;   // test one zone for expiry
    logic flush;  // close a tick: release the held completion or an idle word
    logic exec;   // carry out a start, stop or query
  } mzrt_cmd_t;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  localparam logic [2:0] EV_STARTED   = 3'd0;
  localparam logic [2:0] EV_REJECTED  = 3'd1;
  localparam logic [2:0] EV_STOPPED   = 3'd2;
  localparam logic [2:0] EV_COMPLETED = 3'd3;
  localparam logic [2:0] EV_QUERY     = 3'd4;
  localparam logic [2:0] EV_IDLE      = 3'd5;

  localparam logic [15:0] MAX_DUR_RESET = 16'd3600;

endpackage

### rtl/core/mzrt_datapath.sv
// Datapath of the relay timer: seconds counter, per-zone run records,
// clamp register, held completion word and output register. Uses mzrt_pkg.
module mzrt_datapath #(
  parameter int ZONES = 4,
  parameter int ZW    = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mzrt_pkg::mzrt_cmd_t cmd,
  input  logic [ZW-1:0]      cmd_zone,
  input  mzrt_pkg::in_word_t in_word,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  output logic               out_valid,
  output mzrt_pkg::out_word_t out_word
);
  import mzrt_pkg::*;

  logic [15:0] max_dur_r, max_dur_nxt;
  logic [31:0] seconds_r, seconds_nxt;
  logic [ZONES-1:0] running_r, running_nxt;
  logic [31:0] start_r [ZONES];
  logic [31:0] start_nxt [ZONES];
  logic [15:0] len_r [ZONES];
  logic [15:0] len_nxt [ZONES];
  logic [31:0] prior_end_r [ZONES];
  logic [31:0] prior_end_nxt [ZONES];
  logic [15:0] prior_len_r [ZONES];
  logic [15:0] prior_len_nxt [ZONES];
  in_word_t    item_r, item_nxt;
  out_word_t   pend_r, pend_nxt;
  logic        pend_vld_r, pend_vld_nxt;
  out_word_t   out_r, out_nxt;
  logic        out_vld_r, out_vld_nxt;

  logic          item_ok;
  logic [ZW-1:0] item_z;
  logic [ZW-1:0] sel;
  logic [31:0]   elapsed;
  logic          expired;
  logic [15:0]   ran;
  logic [15:0]   left;
  logic [15:0]   granted;
  logic [7:0]    mask_cur;
  logic [7:0]    sel_bit;

  assign item_ok  = ({1'b0, item_r.zone} < 4'(ZONES));
  assign item_z   = item_ok ? item_r.zone[ZW-1:0] : '0;
  assign sel      = cmd.scan ? cmd_zone : item_z;
  assign elapsed  = seconds_r - start_r[sel];
  assign expired  = (elapsed >= {16'd0, len_r[sel]});
  assign ran      = (elapsed[31:16] != 16'd0) ? 16'hFFFF : elapsed[15:0];
  assign left     = (running_r[sel] && !expired) ? (len_r[sel] - elapsed[15:0]) : 16'd0;
  assign granted  = (item_r.duration_s > max_dur_r) ? max_dur_r : item_r.duration_s;
  assign mask_cur = 8'(running_r);
  assign sel_bit  = 8'(1) << sel;

  always_comb begin
    max_dur_nxt   = cfg_wr_en ? cfg_wr_data : max_dur_r;
    seconds_nxt   = seconds_r;
    running_nxt   = running_r;
    start_nxt     = start_r;
    len_nxt       = len_r;
    prior_end_nxt = prior_end_r;
    prior_len_nxt = prior_len_r;
    item_nxt      = item_r;
    pend_nxt      = pend_r;
    pend_vld_nxt  = pend_vld_r;
    out_nxt       = out_r;
    out_vld_nxt   = 1'b0;

    if (cmd.load) begin
      item_nxt     = in_word;
      pend_vld_nxt = 1'b0;
      if (in_word.opcode == OP_TICK) begin
        seconds_nxt = seconds_r + 32'd1;
      end
    end

    if (cmd.scan && running_r[sel] && expired) begin
      // end this run; release the one held before it, hold this one
      running_nxt[sel]   = 1'b0;
      prior_end_nxt[sel] = seconds_r;
      prior_len_nxt[sel] = ran;
      if (pend_vld_r) begin
        out_nxt     = pend_r;
        out_vld_nxt = 1'b1;
      end
      pend_nxt               = '0;
      pend_nxt.event_res     = EV_COMPLETED;
      pend_nxt.zone_out      = 3'(sel);
      pend_nxt.ran_for_s     = ran;
      pend_nxt.last_end_time = seconds_r;
      pend_nxt.last_run_s    = ran;
      pend_nxt.relay_mask    = mask_cur & ~sel_bit;
      pend_vld_nxt           = 1'b1;
    end

    if (cmd.flush) begin
      out_vld_nxt = 1'b1;
      if (pend_vld_r) begin
        out_nxt = pend_r;
      end else begin
        out_nxt            = '0;
        out_nxt.event_res  = EV_IDLE;
        out_nxt.relay_mask = mask_cur;
      end
      out_nxt.last = 1'b1;
      pend_vld_nxt = 1'b0;
    end

    if (cmd.exec) begin
      out_vld_nxt         = 1'b1;
      out_nxt             = '0;
      out_nxt.event_res   = EV_REJECTED;
      out_nxt.zone_out    = item_r.zone;
      out_nxt.zone_active = item_ok && running_r[sel];
      out_nxt.relay_mask  = mask_cur;
      out_nxt.last        = 1'b1;
      case (item_r.opcode)
        OP_START: begin
          if (item_ok && !running_r[sel] && (item_r.duration_s != 16'd0)) begin
            running_nxt[sel]      = 1'b1;
            start_nxt[sel]        = seconds_r;
            len_nxt[sel]          = granted;
            out_nxt.event_res     = EV_STARTED;
            out_nxt.zone_active   = 1'b1;
            out_nxt.granted_s     = granted;
            out_nxt.remaining_s   = granted;
            out_nxt.last_end_time = prior_end_r[sel];
            out_nxt.last_run_s    = prior_len_r[sel];
            out_nxt.relay_mask    = mask_cur | sel_bit;
          end
        end
        OP_STOP: begin
          if (item_ok && running_r[sel]) begin
            running_nxt[sel]      = 1'b0;
            prior_end_nxt[sel]    = seconds_r;
            prior_len_nxt[sel]    = ran;
            out_nxt.event_res     = EV_STOPPED;
            out_nxt.zone_active   = 1'b0;
            out_nxt.ran_for_s     = ran;
            out_nxt.last_end_time = seconds_r;
            out_nxt.last_run_s    = ran;
            out_nxt.relay_mask    = mask_cur & ~sel_bit;
          end
        end
        OP_QUERY: begin
          if (item_ok) begin
            out_nxt.event_res     = EV_QUERY;
            out_nxt.remaining_s   = left;
            out_nxt.last_end_time = prior_end_r[sel];
            out_nxt.last_run_s    = prior_len_r[sel];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dur_r   <= MAX_DUR_RESET;
      seconds_r   <= '0;
      running_r   <= '0;
      pend_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
      for (int i = 0; i < ZONES; i++) begin
        start_r[i]     <= '0;
        len_r[i]       <= '0;
        prior_end_r[i] <= '0;
        prior_len_r[i] <= '0;
      end
    end else begin
      max_dur_r   <= max_dur_nxt;
      seconds_r   <= seconds_nxt;
      running_r   <= running_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_vld_r   <= out_vld_nxt;
      start_r     <= start_nxt;
      len_r       <= len_nxt;
      prior_end_r <= prior_end_nxt;
      prior_len_r <= prior_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_r;

endmodule

### rtl/core/mzrt_ctrl.sv
// Controller of the relay timer: sequences the zone scan of a tick and the
// single step of a start, stop or query. Uses mzrt_pkg.
module mzrt_ctrl #(
  parameter int ZONES = 4,
  parameter int ZW    = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_is_tick,
  output logic                busy,
  output mzrt_pkg::mzrt_cmd_t cmd,
  output logic [ZW-1:0]       cmd_zone
);
  import mzrt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_EXEC
  } state_t;

  state_t        state_r, state_nxt;
  logic [ZW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = in_is_tick ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (cnt_r == ZW'(ZONES - 1)) begin
          state_nxt = S_FLUSH;
        end else begin
          cnt_nxt = cnt_r + ZW'(1);
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_IDLE;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy     = busy_r;
  assign cmd_zone = cnt_r;

endmodule

### rtl/core/multi_zone_relay_timer.sv
// Top level of the multi-zone relay timer: controller plus datapath.
// Uses mzrt_pkg, mzrt_ctrl and mzrt_datapath.
//
// A word is taken on a rising edge with start high and busy low. Start, stop
// and query words keep busy high through the single execute state and put
// one result word on the ports from the output register once that state is
// done, so the next word can be taken as soon as busy falls.
// A tick word advances the seconds counter on acceptance and then walks the
// zones one per cycle through the single shared elapsed-time subtractor and
// compare, with busy high through the scan and the flush state that follows
// it, so the next word waits for both. Each expired zone yields a
// completion word; the last word of a tick is found by holding each completion
// back until the next one or the end of the scan, and a tick with nothing to
// finish yields one idle word. Results come out of a register with out_valid
// high for exactly one cycle each; there is no back-pressure, so the receiver
// must take every word as it appears. Every accepted word ends with exactly
// one result marked by last. Write max_duration_s through cfg_wr_en and
// cfg_wr_data only while busy is low and no results are outstanding.
module multi_zone_relay_timer #(
  parameter int ZONES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mzrt_pkg::in_word_t  in_word,
  output logic                out_valid,
  output mzrt_pkg::out_word_t out_word,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data
);
  import mzrt_pkg::*;

  // width of a zone index; keep one bit even for a single zone
  localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;

  mzrt_cmd_t     cmd;
  logic [ZW-1:0] cmd_zone;
  logic          in_is_tick;

  assign in_is_tick = (in_word.opcode == OP_TICK);

  // sequence the scan and the single-step operations
  mzrt_ctrl #(
    .ZONES (ZONES),
    .ZW    (ZW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_is_tick (in_is_tick),
    .busy       (busy),
    .cmd        (cmd),
    .cmd_zone   (cmd_zone)
  );

  // hold the zone records and build every result word
  mzrt_datapath #(
    .ZONES (ZONES),
    .ZW    (ZW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cmd_zone    (cmd_zone),
    .in_word     (in_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_word    (out_word)
  );

endmodule

### rtl/core/mzrt_checker.sv
// Port-level checks for the relay timer, bound to the top level.
// Uses mzrt_pkg; attaches to multi_zone_relay_timer.
module mzrt_checker #(
  parameter int ZONES = 4
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input mzrt_pkg::out_word_t out_word
);
  import mzrt_pkg::*;

  // an accepted word always raises busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after acceptance");

  // the final word of one item is never directly followed by another word
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last |=> !out_valid)
    else $error("result word directly after a final word");

  // a finished run reports the zone off and its length as the last run
  a_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.event_res == EV_COMPLETED ||
                  out_word.event_res == EV_STOPPED)
    |-> !out_word.zone_active && (out_word.ran_for_s == out_word.last_run_s))
    else $error("ended run reported inconsistently");

  // no relay beyond the configured zones is ever driven
  a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((16'(out_word.relay_mask) >> ZONES) == 16'd0))
    else $error("relay bit set for a missing zone");

  // nothing is busy or emitted right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("activity straight after reset");

endmodule

bind multi_zone_relay_timer mzrt_checker #(.ZONES(ZONES)) u_mzrt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for multi_zone_relay_timer: a zone timer tracker
// predicts every result word. Depends on mzrt_pkg and the RTL of the block.
import mzrt_pkg::*;

localparam int ZONES = 4;

class zone_timer_tracker;
  int unsigned errors;
  logic [15:0] max_dur;
  logic [31:0] now_s;
  bit          running [ZONES];
  logic [31:0] start_t [ZONES];
  logic [15:0] length_s [ZONES];
  logic [31:0] end_t [ZONES];
  logic [15:0] prev_len [ZONES];
  out_word_t   due_words [$];
  out_word_t   held;
  bit          held_valid;

  function new();
    errors = 0;
    max_dur = MAX_DUR_RESET;
    now_s = '0;
    held_valid = 0;
    for (int i = 0; i < ZONES; i++) begin
      running[i] = 0;
      start_t[i] = '0;
      length_s[i] = '0;
      end_t[i] = '0;
      prev_len[i] = '0;
    end
  endfunction

  function void set_clamp(logic [15:0] v);
    max_dur = v;
  endfunction

  function int outstanding();
    return due_words.size();
  endfunction

  function logic [7:0] relay_bits();
    logic [7:0] m;
    m = '0;
    for (int i = 0; i < ZONES; i++)
      if (running[i]) m[i] = 1'b1;
    return m;
  endfunction

  function out_word_t result_of(logic [2:0] ev, logic [2:0] zn, logic act,
                                logic [15:0] granted, logic [15:0] ran,
                                logic [15:0] rem, logic [31:0] endt,
                                logic [15:0] lastrun);
    out_word_t r;
    r.event_res     = ev;
    r.zone_out      = zn;
    r.zone_active   = act;
    r.granted_s     = granted;
    r.ran_for_s     = ran;
    r.remaining_s   = rem;
    r.last_end_time = endt;
    r.last_run_s    = lastrun;
    r.relay_mask    = relay_bits();
    r.last          = 1'b0;
    return r;
  endfunction

  // Hold each word back until the next one shows it was not the final one.
  function void stage(out_word_t r);
    if (held_valid) due_words.push_back(held);
    held = r;
    held_valid = 1;
  endfunction

  function void close_item();
    held.last = 1'b1;
    due_words.push_back(held);
    held_valid = 0;
  endfunction

  function logic [15:0] end_run(int z);
    logic [31:0] ran;
    ran = now_s - start_t[z];
    if (ran > 32'h0000_FFFF) ran = 32'h0000_FFFF;
    running[z] = 0;
    end_t[z] = now_s;
    prev_len[z] = ran[15:0];
    return ran[15:0];
  endfunction

  function logic [15:0] time_left(int z);
    logic [31:0] elapsed, left;
    if (!running[z]) return '0;
    elapsed = now_s - start_t[z];
    if (elapsed >= {16'h0000, length_s[z]}) return '0;
    left = {16'h0000, length_s[z]} - elapsed;
    return left[15:0];
  endfunction

  function void take_word(in_word_t w);
    int          z;
    bit          ok;
    bit          any;
    logic        act;
    logic [15:0] g, ran;
    ok = (w.zone < ZONES);
    z = ok ? int'(w.zone) : 0;
    act = ok && running[z];
    case (w.opcode)
      OP_TICK: begin
        now_s = now_s + 32'd1;
        any = 0;
        for (int i = 0; i < ZONES; i++) begin
          if (running[i] && (now_s - start_t[i]) >= {16'h0000, length_s[i]}) begin
            ran = end_run(i);
            stage(result_of(EV_COMPLETED, 3'(i), 1'b0, '0, ran, '0, now_s, ran));
            any = 1;
          end
        end
        if (!any) stage(result_of(EV_IDLE, '0, 1'b0, '0, '0, '0, '0, '0));
      end
      OP_START: begin
        if (!ok || running[z] || w.duration_s == '0) begin
          stage(result_of(EV_REJECTED, w.zone, act, '0, '0, '0, '0, '0));
        end else begin
          g = (w.duration_s > max_dur) ? max_dur : w.duration_s;
          running[z] = 1;
          start_t[z] = now_s;
          length_s[z] = g;
          stage(result_of(EV_STARTED, w.zone, 1'b1, g, '0, g, end_t[z], prev_len[z]));
        end
      end
      OP_STOP: begin
        if (!ok || !running[z]) begin
          stage(result_of(EV_REJECTED, w.zone, act, '0, '0, '0, '0, '0));
        end else begin
          ran = end_run(z);
          stage(result_of(EV_STOPPED, w.zone, 1'b0, '0, ran, '0, now_s, ran));
        end
      end
      default: begin
        if (!ok)
          stage(result_of(EV_REJECTED, w.zone, 1'b0, '0, '0, '0, '0, '0));
        else
          stage(result_of(EV_QUERY, w.zone, act, '0, '0, time_left(z), end_t[z],
                          prev_len[z]));
      end
    endcase
    close_item();
  endfunction

  function void compare(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  function void check_word(out_word_t got);
    out_word_t want;
    if (due_words.size() == 0) begin
      $error("result word with none due: event_res %0d zone_out %0d",
             got.event_res, got.zone_out);
      errors++;
      return;
    end
    want = due_words.pop_front();
    compare("event_res", want.event_res, got.event_res);
    compare("zone_out", want.zone_out, got.zone_out);
    compare("zone_active", want.zone_active, got.zone_active);
    compare("granted_s", want.granted_s, got.granted_s);
    compare("ran_for_s", want.ran_for_s, got.ran_for_s);
    compare("remaining_s", want.remaining_s, got.remaining_s);
    compare("last_end_time", want.last_end_time, got.last_end_time);
    compare("last_run_s", want.last_run_s, got.last_run_s);
    compare("relay_mask", want.relay_mask, got.relay_mask);
    compare("last", want.last, got.last);
  endfunction
endclass

module testbench;
  // Longest stretch with no word moving either way: the slowest sender idles
  // each cycle with a chance of 86 in a hundred, and a tick scan walks each
  // zone only once, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 3000;
  // Cycles to let pass once nothing is due: covers a full tick scan.
  localparam int SETTLE_CYCLES  = ZONES + 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_word_t    in_word = '0;
  logic        out_valid;
  out_word_t   out_word;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  zone_timer_tracker timer_model;
  int unsigned       quiet_cycles = 0;

  always #2 clk = ~clk;

  multi_zone_relay_timer #(.ZONES(ZONES)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Sample both channels on the rising edge: every value read here is the one
  // that settled before the edge, so no ordering within the step matters.
  // Predict on each accepted input word, check each strobed result word, and
  // drop the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) timer_model.take_word(in_word);
      if (out_valid) timer_model.check_word(out_word);
      if ((start && !busy) || out_valid)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Present a word and hold it until the edge that takes it. Busy is read
  // after the edge, so it is the value the block showed at that edge.
  task automatic send_word(input in_word_t w);
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [2:0] zn,
                         input logic [15:0] dur);
    in_word_t w;
    w.opcode = op;
    w.zone = zn;
    w.duration_s = dur;
    send_word(w);
  endtask

  // Idle the sender for a random number of cycles; pct is the chance in a
  // hundred that any one cycle stays idle.
  task automatic hold_off(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop start and wait until every due word has come, then let the block
  // finish whatever scan it may still be in.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (timer_model.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only ever called with the block idle, straight after settle.
  task automatic write_clamp(input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    timer_model.set_clamp(v);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly valid zones and short runs so that completions happen often; now
  // and then a bad zone, a zero length, a full-range length or the maximum.
  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 40)      w.opcode = OP_TICK;
    else if (pick < 70) w.opcode = OP_START;
    else if (pick < 85) w.opcode = OP_STOP;
    else                w.opcode = OP_QUERY;
    if ($urandom_range(9) < 8) w.zone = 3'($urandom_range(ZONES - 1));
    else                       w.zone = 3'($urandom_range(7));
    case ($urandom_range(9))
      0:       w.duration_s = '0;
      1:       w.duration_s = 16'($urandom_range(65535));
      2:       w.duration_s = 16'hFFFF;
      default: w.duration_s = 16'($urandom_range(12, 1));
    endcase
    return w;
  endfunction

  task automatic random_phase(input int pct, input int count, input logic [15:0] clamp);
    settle();
    write_clamp(clamp);
    for (int i = 0; i < count; i++) begin
      hold_off(pct);
      // Now and then pause the sender until every due word is back.
      if ($urandom_range(39) == 0) settle();
      send_word(random_word());
    end
  endtask

  task automatic directed_checks();
    // Reset clamp of 3600 s: rejections of every kind, clamping, and two
    // zones expiring in one tick.
    send_op(OP_TICK,  3'd0, 16'd0);      // nothing running: idle word
    send_op(OP_QUERY, 3'd0, 16'd0);      // untouched zone history
    send_op(OP_START, 3'd0, 16'd0);      // zero length
    send_op(OP_START, 3'd0, 16'd2);
    send_op(OP_START, 3'd0, 16'd5);      // zone already running
    send_op(OP_START, 3'd7, 16'hFFFF);   // zone out of range
    send_op(OP_STOP,  3'd5, 16'd0);      // zone out of range
    send_op(OP_STOP,  3'd1, 16'd0);      // zone not running
    send_op(OP_QUERY, 3'd4, 16'd0);      // zone out of range
    send_op(OP_START, 3'd1, 16'hFFFF);   // clamped to 3600
    send_op(OP_START, 3'd2, 16'd1);
    send_op(OP_START, 3'd3, 16'd1);
    send_op(OP_QUERY, 3'd0, 16'd0);
    send_op(OP_TICK,  3'd0, 16'd0);      // zones 2 and 3 complete together
    send_op(OP_TICK,  3'd0, 16'd0);      // zone 0 completes
    send_op(OP_STOP,  3'd1, 16'd0);      // stopped on request
    send_op(OP_QUERY, 3'd1, 16'd0);
    send_op(OP_QUERY, 3'd0, 16'd0);
    // Zero clamp: granted nothing, yet on until the next tick.
    settle();
    write_clamp(16'd0);
    send_op(OP_START, 3'd0, 16'd9);
    send_op(OP_QUERY, 3'd0, 16'd0);
    send_op(OP_TICK,  3'd0, 16'd0);
    // Clamp of one: every zone expires in the same tick.
    settle();
    write_clamp(16'd1);
    for (int z = 0; z < ZONES; z++) send_op(OP_START, 3'(z), 16'd100);
    send_op(OP_TICK,  3'd0, 16'd0);
    // Widest clamp: the full requested length is granted.
    settle();
    write_clamp(16'hFFFF);
    send_op(OP_START, 3'd1, 16'hFFFF);
    send_op(OP_TICK,  3'd0, 16'd0);
    send_op(OP_STOP,  3'd1, 16'd0);
  endtask

  initial begin
    timer_model = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    directed_checks();
    // Sparse sender with a short clamp, then a mostly idle sender with the
    // widest clamp, then back-to-back words with a clamp anywhere in range.
    random_phase(34, 107, 16'($urandom_range(20, 1)));
    random_phase(86, 107, 16'hFFFF);
    random_phase(0, 107, 16'($urandom_range(65535, 1)));
    settle();
    if (timer_model.errors == 0 && timer_model.outstanding() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end
endmodule
